### hw/rtl/hpt_pkg.sv
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared widths, register indexes and constants for the homography point
// transform.
// ----------------------------------------------------------------------------
package hpt_pkg;

  localparam int COEF_W = 32;
  localparam int PT_W   = 24;
  localparam int OUT_W  = 32;
  localparam int PROD_W = COEF_W + PT_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int LOW_W  = 24;
  localparam int DIG_W  = 32;
  localparam int IDX_W  = 3;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic        [SUM_W-1:0]  mag_t;

  localparam logic [IDX_W-1:0] REG_PAIR0 = 3'd0;
  localparam logic [IDX_W-1:0] REG_PAIR1 = 3'd1;
  localparam logic [IDX_W-1:0] REG_PAIR2 = 3'd2;
  localparam logic [IDX_W-1:0] REG_PAIR3 = 3'd3;
  localparam logic [IDX_W-1:0] REG_LAST  = 3'd4;

  localparam logic [OUT_W-1:0] OUT_INVALID = 32'hFFFF_FF00;
  localparam logic [OUT_W-1:0] OUT_MAX     = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0] OUT_MIN     = 32'h8000_0000;
  localparam logic [63:0]      COEF_ONE    = 64'd65536;

endpackage

### hw/rtl/homography_point_transform_core.sv
// ----------------------------------------------------------------------------
// homography_point_transform_core
// Projective 3x3 point transform: (x, y, w) -> (u/s, v/s), Q24.8 outputs.
//
//   channel   signals                              direction
//   input     start, busy, in_x, in_y, in_w        in (busy out)
//   config    cfg_valid, cfg_ready, cfg_index,     in (cfg_ready out)
//             cfg_data
//   result    done, out_x, out_y, out_valid        out
//
// One point enters every cycle; busy stays low. Its stages, in order, are
// multiply, sum, magnitude, 32 quotient-bit stages of the two restoring
// dividers (one bit per stage), and the saturating output register.
// Synchronous reset clears all stage valid bits and loads the identity matrix.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module homography_point_transform_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [23:0]         in_x,
  input  logic signed [23:0]         in_y,
  input  logic signed [23:0]         in_w,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [hpt_pkg::IDX_W-1:0]  cfg_index,
  input  logic [63:0]                cfg_data,
  output logic                       done,
  output logic signed [31:0]         out_x,
  output logic signed [31:0]         out_y,
  output logic                       out_valid
);
  import hpt_pkg::*;

  logic [63:0] pair0, pair1, pair2, pair3;
  coef_t       clast;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pair0 <= COEF_ONE;
      pair1 <= '0;
      pair2 <= COEF_ONE;
      pair3 <= '0;
      clast <= coef_t'(COEF_ONE[COEF_W-1:0]);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PAIR0: pair0 <= cfg_data;
        REG_PAIR1: pair1 <= cfg_data;
        REG_PAIR2: pair2 <= cfg_data;
        REG_PAIR3: pair3 <= cfg_data;
        REG_LAST:  clast <= coef_t'(cfg_data[COEF_W-1:0]);
        default: ;
      endcase
    end
  end

  // multiply
  logic  vld1;
  prod_t p [0:8];
  always_ff @(posedge clk) begin
    if (rst) vld1 <= 1'b0;
    else     vld1 <= start && !busy;
    p[0] <= signed'(pair0[31:0])  * in_x;
    p[1] <= signed'(pair0[63:32]) * in_y;
    p[2] <= signed'(pair1[31:0])  * in_w;
    p[3] <= signed'(pair1[63:32]) * in_x;
    p[4] <= signed'(pair2[31:0])  * in_y;
    p[5] <= signed'(pair2[63:32]) * in_w;
    p[6] <= signed'(pair3[31:0])  * in_x;
    p[7] <= signed'(pair3[63:32]) * in_y;
    p[8] <= clast * in_w;
  end

  // sum
  logic vld2;
  sum_t su, sv, ss;
  always_ff @(posedge clk) begin
    if (rst) vld2 <= 1'b0;
    else     vld2 <= vld1;
    su <= sum_t'(p[0]) + sum_t'(p[1]) + sum_t'(p[2]);
    sv <= sum_t'(p[3]) + sum_t'(p[4]) + sum_t'(p[5]);
    ss <= sum_t'(p[6]) + sum_t'(p[7]) + sum_t'(p[8]);
  end

  // magnitude, overflow check, divider seed
  mag_t ma, mb, md;
  assign ma = su[SUM_W-1] ? mag_t'(-su) : mag_t'(su);
  assign mb = sv[SUM_W-1] ? mag_t'(-sv) : mag_t'(sv);
  assign md = ss[SUM_W-1] ? mag_t'(-ss) : mag_t'(ss);

  logic             vld [0:DIG_W];
  logic             zr  [0:DIG_W];
  logic             ngx [0:DIG_W];
  logic             ngy [0:DIG_W];
  logic             stx [0:DIG_W];
  logic             sty [0:DIG_W];
  mag_t             den [0:DIG_W];
  mag_t             rx  [0:DIG_W];
  mag_t             ry  [0:DIG_W];
  logic [DIG_W-1:0] lx  [0:DIG_W];
  logic [DIG_W-1:0] ly  [0:DIG_W];
  logic [DIG_W-1:0] qx  [0:DIG_W];
  logic [DIG_W-1:0] qy  [0:DIG_W];

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else     vld[0] <= vld2;
    zr[0]  <= (ss == '0);
    ngx[0] <= su[SUM_W-1] ^ ss[SUM_W-1];
    ngy[0] <= sv[SUM_W-1] ^ ss[SUM_W-1];
    stx[0] <= mag_t'(ma[SUM_W-1:LOW_W]) >= md;
    sty[0] <= mag_t'(mb[SUM_W-1:LOW_W]) >= md;
    den[0] <= md;
    rx[0]  <= mag_t'(ma[SUM_W-1:LOW_W]);
    ry[0]  <= mag_t'(mb[SUM_W-1:LOW_W]);
    lx[0]  <= {ma[LOW_W-1:0], 8'd0};
    ly[0]  <= {mb[LOW_W-1:0], 8'd0};
    qx[0]  <= '0;
    qy[0]  <= '0;
  end

  // one quotient bit per stage
  for (genvar k = 0; k < DIG_W; k++) begin : g_div
    logic [SUM_W:0] tx, ty, dx, dy;
    assign tx = {rx[k], lx[k][DIG_W-1]};
    assign ty = {ry[k], ly[k][DIG_W-1]};
    assign dx = tx - {1'b0, den[k]};
    assign dy = ty - {1'b0, den[k]};

    always_ff @(posedge clk) begin
      if (rst) vld[k+1] <= 1'b0;
      else     vld[k+1] <= vld[k];
      zr[k+1]  <= zr[k];
      ngx[k+1] <= ngx[k];
      ngy[k+1] <= ngy[k];
      stx[k+1] <= stx[k];
      sty[k+1] <= sty[k];
      den[k+1] <= den[k];
      lx[k+1]  <= {lx[k][DIG_W-2:0], 1'b0};
      ly[k+1]  <= {ly[k][DIG_W-2:0], 1'b0};
      if (!dx[SUM_W]) begin
        rx[k+1] <= dx[SUM_W-1:0];
        qx[k+1] <= {qx[k][DIG_W-2:0], 1'b1};
      end else begin
        rx[k+1] <= tx[SUM_W-1:0];
        qx[k+1] <= {qx[k][DIG_W-2:0], 1'b0};
      end
      if (!dy[SUM_W]) begin
        ry[k+1] <= dy[SUM_W-1:0];
        qy[k+1] <= {qy[k][DIG_W-2:0], 1'b1};
      end else begin
        ry[k+1] <= ty[SUM_W-1:0];
        qy[k+1] <= {qy[k][DIG_W-2:0], 1'b0};
      end
    end
  end

  function automatic logic [OUT_W-1:0] sat_q(logic [DIG_W-1:0] q, logic ng, logic st);
    logic [OUT_W-1:0] r;
    if (ng) begin
      if (st || q > OUT_MIN) r = OUT_MIN;
      else                   r = OUT_W'(-q);
    end else begin
      if (st || q > OUT_MAX) r = OUT_MAX;
      else                   r = q;
    end
    return r;
  endfunction

  // saturate and drive results
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= vld[DIG_W];
    out_valid <= !zr[DIG_W];
    if (zr[DIG_W]) begin
      out_x <= OUT_INVALID;
      out_y <= OUT_INVALID;
    end else begin
      out_x <= sat_q(qx[DIG_W], ngx[DIG_W], stx[DIG_W]);
      out_y <= sat_q(qy[DIG_W], ngy[DIG_W], sty[DIG_W]);
    end
  end

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(vld[DIG_W])) else $error("result without item");
  a_invalid_val: assert property (@(posedge clk) disable iff (rst)
    (done && !out_valid) |-> (out_x == OUT_INVALID && out_y == OUT_INVALID))
    else $error("invalid point not reported as -1");
  a_latency: assert property (@(posedge clk) disable iff (rst)
    vld2 |=> vld[0]) else $error("item lost after sum");
  a_never_busy: assert property (@(posedge clk) !busy) else $error("busy raised");

endmodule
